FILE: design/lc3_instruction_step_unit_assert.svh
// Assertion macros for the LC-3 instruction step unit.
// Expects signals named clock and reset in the including module.
`ifndef LC3_INSTRUCTION_STEP_UNIT_ASSERT_SVH
`define LC3_INSTRUCTION_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define LC3S_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LC3S_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lc3s_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the LC-3 instruction step unit.
// No dependencies.
package lc3s_pkg;

   localparam int MEM_WORDS = 65536;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam logic [15:0] KBSR_ADDR  = 16'hfe00;
   localparam logic [15:0] KBDR_ADDR  = 16'hfe02;
   localparam logic [15:0] DSR_ADDR   = 16'hfe04;
   localparam logic [15:0] DDR_ADDR   = 16'hfe06;
   localparam logic [7:0]  KEY_TRAP   = 8'h20;
   localparam logic [15:0] READY_WORD = 16'h8000;
   localparam int          COND_BITS  = 3;
   localparam logic [2:0]  COND_MASK  = 3'((1 << COND_BITS) - 1);

   localparam logic [1:0] KIND_EXEC   = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_SETPC  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HALT     = 3'd1;
   localparam logic [2:0] ST_RD_FAULT = 3'd2;
   localparam logic [2:0] ST_WR_FAULT = 3'd3;
   localparam logic [2:0] ST_UNIMPL   = 3'd4;

   localparam logic [1:0] CSR_HANDLER = 2'd0;
   localparam logic [1:0] CSR_INFO    = 2'd1;
   localparam logic [1:0] CSR_MASK    = 2'd2;

   typedef enum logic [3:0] {
      OP_BR, OP_ADD, OP_LD, OP_ST, OP_JSR, OP_AND, OP_LDR, OP_STR,
      OP_RTI, OP_NOT, OP_LDI, OP_STI, OP_JMP, OP_RES, OP_LEA, OP_TRAP
   } opcode_type;

   typedef enum logic [4:0] {
      U_FETCH, U_DECODE, U_BR, U_ALU, U_LD, U_LDWB, U_LDR, U_ST, U_STR,
      U_LDI, U_LDI2, U_LDI3, U_STI, U_STI2, U_STI3, U_JSR, U_JMP, U_RTI,
      U_RES, U_TRAP, U_TRAPRD, U_TRAPPC, U_FAULT, U_LOAD, U_SETPC, U_DONE
   } upc_type;

   typedef enum logic [2:0] {MO_NONE, MO_READ, MO_WRITE, MO_RAW, MO_SOFT} mem_op_type;
   typedef enum logic [2:0] {AS_PC, AS_A1, AS_BOFF, AS_MAR, AS_VEC, AS_INFO, AS_LOAD}
      addr_sel_type;
   typedef enum logic [1:0] {WS_REG_D, WS_AT, WS_LOAD} wdata_sel_type;
   typedef enum logic [3:0] {
      RA_NONE, RA_IR, RA_BR, RA_ALU, RA_LOADREG, RA_MAR, RA_SETCC, RA_JSR,
      RA_JMP, RA_RTI, RA_RES, RA_TRAP, RA_TRAPPC, RA_FAULT, RA_SETPC, RA_EMIT
   } reg_act_type;
   typedef enum logic [2:0] {NX_SEQ, NX_JUMP, NX_DISPATCH, NX_COND, NX_EMIT} next_type;

   typedef struct packed {
      mem_op_type    mem_op;
      addr_sel_type  asel;
      wdata_sel_type wsel;
      reg_act_type   ract;
      next_type      nx;
      upc_type       jmp_tgt;
      upc_type       flt_tgt;
   } ucode_type;

   typedef struct packed {
      logic       fault;
      logic       keyvec;
      opcode_type opcode;
      logic       out_free;
   } dp_stat_type;

   function automatic ucode_type uw(mem_op_type m, addr_sel_type a, wdata_sel_type ws,
                                    reg_act_type r, next_type n, upc_type j, upc_type f);
      ucode_type w;
      w.mem_op  = m;
      w.asel    = a;
      w.wsel    = ws;
      w.ract    = r;
      w.nx      = n;
      w.jmp_tgt = j;
      w.flt_tgt = f;
      return w;
   endfunction

   localparam ucode_type UC_NOP = uw(MO_NONE, AS_PC, WS_REG_D, RA_NONE, NX_SEQ, U_DONE, U_DONE);

   function automatic ucode_type ucode_rom(upc_type u);
      ucode_type w;
      unique case (u)
         U_FETCH:  w = uw(MO_READ,  AS_PC,   WS_REG_D, RA_NONE,    NX_SEQ,  U_DONE, U_DONE);
         U_DECODE: w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_IR,  NX_DISPATCH, U_DONE, U_DONE);
         U_BR:     w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_BR,      NX_JUMP, U_DONE, U_DONE);
         U_ALU:    w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_ALU,     NX_JUMP, U_DONE, U_DONE);
         U_LD:     w = uw(MO_READ,  AS_A1,   WS_REG_D, RA_NONE,    NX_SEQ,  U_DONE, U_FAULT);
         U_LDWB:   w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_LOADREG, NX_JUMP, U_DONE, U_DONE);
         U_LDR:    w = uw(MO_READ,  AS_BOFF, WS_REG_D, RA_NONE,    NX_JUMP, U_LDWB, U_FAULT);
         U_ST:     w = uw(MO_WRITE, AS_A1,   WS_REG_D, RA_NONE,    NX_JUMP, U_DONE, U_FAULT);
         U_STR:    w = uw(MO_WRITE, AS_BOFF, WS_REG_D, RA_NONE,    NX_JUMP, U_DONE, U_FAULT);
         U_LDI:    w = uw(MO_READ,  AS_A1,   WS_REG_D, RA_NONE,    NX_SEQ,  U_DONE, U_FAULT);
         U_LDI2:   w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_MAR,     NX_SEQ,  U_DONE, U_DONE);
         U_LDI3:   w = uw(MO_READ,  AS_MAR,  WS_REG_D, RA_NONE,    NX_JUMP, U_LDWB, U_FAULT);
         U_STI:    w = uw(MO_READ,  AS_A1,   WS_REG_D, RA_NONE,    NX_SEQ,  U_DONE, U_FAULT);
         U_STI2:   w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_MAR,     NX_SEQ,  U_DONE, U_DONE);
         U_STI3:   w = uw(MO_WRITE, AS_MAR,  WS_REG_D, RA_SETCC,   NX_JUMP, U_DONE, U_FAULT);
         U_JSR:    w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_JSR,     NX_JUMP, U_DONE, U_DONE);
         U_JMP:    w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_JMP,     NX_JUMP, U_DONE, U_DONE);
         U_RTI:    w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_RTI,     NX_JUMP, U_DONE, U_DONE);
         U_RES:    w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_RES,     NX_JUMP, U_FAULT, U_DONE);
         U_TRAP:   w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_TRAP,    NX_COND, U_DONE, U_DONE);
         U_TRAPRD: w = uw(MO_READ,  AS_VEC,  WS_REG_D, RA_NONE,    NX_SEQ,  U_DONE, U_FAULT);
         U_TRAPPC: w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_TRAPPC,  NX_JUMP, U_DONE, U_DONE);
         U_FAULT:  w = uw(MO_SOFT,  AS_INFO, WS_AT,    RA_FAULT,   NX_JUMP, U_DONE, U_DONE);
         U_LOAD:   w = uw(MO_RAW,   AS_LOAD, WS_LOAD,  RA_NONE,    NX_JUMP, U_DONE, U_DONE);
         U_SETPC:  w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_SETPC,   NX_JUMP, U_DONE, U_DONE);
         U_DONE:   w = uw(MO_NONE,  AS_PC,   WS_REG_D, RA_EMIT,    NX_EMIT, U_DONE, U_DONE);
         default:  w = UC_NOP;
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch(opcode_type op);
      upc_type u;
      unique case (op)
         OP_BR:                         u = U_BR;
         OP_ADD, OP_AND, OP_NOT, OP_LEA: u = U_ALU;
         OP_LD:                         u = U_LD;
         OP_LDR:                        u = U_LDR;
         OP_ST:                         u = U_ST;
         OP_STR:                        u = U_STR;
         OP_LDI:                        u = U_LDI;
         OP_STI:                        u = U_STI;
         OP_JSR:                        u = U_JSR;
         OP_JMP:                        u = U_JMP;
         OP_RTI:                        u = U_RTI;
         OP_RES:                        u = U_RES;
         OP_TRAP:                       u = U_TRAP;
         default:                       u = U_DONE;
      endcase
      return u;
   endfunction

   function automatic upc_type entry_upc(logic [1:0] kind);
      upc_type u;
      unique case (kind)
         KIND_EXEC:  u = U_FETCH;
         KIND_LOAD:  u = U_LOAD;
         KIND_SETPC: u = U_SETPC;
         default:    u = U_DONE;
      endcase
      return u;
   endfunction

endpackage

FILE: design/lc3s_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup, dispatch and jumps.
// Depends on lc3s_pkg and the assertion macro header.
`include "lc3_instruction_step_unit_assert.svh"
module lc3s_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  lc3s_pkg::dp_stat_type  stat,
   output lc3s_pkg::ucode_type    cw,
   output logic                   start
);

   logic              busy_ff, busy_in;
   lc3s_pkg::upc_type upc_ff, upc_in, upc_seq;

   assign req_ready = !busy_ff;
   assign start     = req_valid && !busy_ff;
   assign upc_seq   = lc3s_pkg::upc_type'(5'(upc_ff) + 5'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= lc3s_pkg::U_FETCH;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   always_comb begin
      cw      = busy_ff ? lc3s_pkg::ucode_rom(upc_ff) : lc3s_pkg::UC_NOP;
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = lc3s_pkg::entry_upc(req_kind);
         end
      end else if (stat.fault) begin
         upc_in = cw.flt_tgt;
      end else begin
         unique case (cw.nx)
            lc3s_pkg::NX_SEQ:      upc_in = upc_seq;
            lc3s_pkg::NX_JUMP:     upc_in = cw.jmp_tgt;
            lc3s_pkg::NX_DISPATCH: upc_in = lc3s_pkg::dispatch(stat.opcode);
            lc3s_pkg::NX_COND:     upc_in = stat.keyvec ? cw.jmp_tgt : upc_seq;
            lc3s_pkg::NX_EMIT: begin
               if (stat.out_free) busy_in = 1'b0;
            end
            default:               upc_in = lc3s_pkg::U_DONE;
         endcase
      end
   end

   `LC3S_ASSERT_NXT(a_start_busy, start, busy_ff, "accepted item did not start")
   `LC3S_ASSERT_NXT(a_fault_redirect, busy_ff && stat.fault, upc_ff == $past(cw.flt_tgt), "fault did not redirect")
   `LC3S_ASSERT_NXT(a_done_hold, busy_ff && (upc_ff == lc3s_pkg::U_DONE) && !stat.out_free, busy_ff && (upc_ff == lc3s_pkg::U_DONE), "result lost while output full")
   `LC3S_ASSERT_NXT(a_done_release, busy_ff && (upc_ff == lc3s_pkg::U_DONE) && stat.out_free, !busy_ff, "sequencer did not release")

endmodule

FILE: design/lc3s_dpath.sv
`timescale 1ns / 1ps
// Datapath: register file, PC, word memory, memory map, fault logic and result register.
// Depends on lc3s_pkg; driven by the control word from lc3s_useq.
module lc3s_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  lc3s_pkg::ucode_type    cw,
   input  logic                   start,
   output lc3s_pkg::dp_stat_type  stat,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic [15:0]            req_word_address,
   input  logic [15:0]            req_word_data,
   input  logic                   req_key_ready,
   input  logic [7:0]             req_key_char,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [15:0]            rsp_fault_address,
   output logic                   rsp_handler_taken,
   output logic [15:0]            rsp_pc_now,
   output logic                   rsp_display_valid,
   output logic [15:0]            rsp_display_word,
   output logic                   rsp_key_taken,
   output logic                   rsp_rti_request,
   output logic [15:0]            rsp_rti_first,
   output logic [15:0]            rsp_rti_second,
   output logic signed [5:0]      rsp_rti_offset
);

   logic [15:0] mem [lc3s_pkg::MEM_WORDS];

   logic [15:0] handler_ff, info_ff;
   logic [2:0]  mask_ff;
   logic [15:0] waddr_ff, wdata_ff;
   logic        kready_ff;
   logic [7:0]  kchar_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, at_ff, ir_ff, mar_ff, count_ff, memq_ff, io_val_ff;
   logic [2:0]  flag_ff;
   logic        io_hit_ff;
   logic [2:0]  status_ff;
   logic [15:0] faddr_ff, dispw_ff, rfirst_ff, rsecond_ff;
   logic        taken_ff, dispv_ff, took_ff, rti_ff;
   logic [5:0]  roff_ff;
   logic        rsp_valid_ff;

   logic [2:0]  fd, fb, fs;
   logic [15:0] off9, off6, imm5, off11, a1, boff, rd_data, addr, wdat, src2, alu;
   logic [15:0] flag_val, jsr_tgt, io_val;
   logic [2:0]  cc;
   logic        is_io, in_range, acc_fault, fault_en, keyvec, out_free, mem_we, disp_we;
   logic        act;
   logic        rf_we;
   logic [2:0]  rf_wa;
   logic [15:0] rf_wd;

   assign fd    = ir_ff[11:9];
   assign fb    = ir_ff[8:6];
   assign fs    = ir_ff[2:0];
   assign off9  = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6  = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign imm5  = {{11{ir_ff[4]}}, ir_ff[4:0]};
   assign off11 = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign a1    = pc_ff + off9;
   assign boff  = regs_ff[fb] + off6;
   assign rd_data = io_hit_ff ? io_val_ff : memq_ff;
   assign keyvec  = (ir_ff[7:0] == lc3s_pkg::KEY_TRAP);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign flag_val = regs_ff[flag_ff];
   assign cc = {flag_val[15], flag_val == 16'd0, !flag_val[15] && (flag_val != 16'd0)};
   assign src2 = ir_ff[5] ? imm5 : regs_ff[fs];
   assign jsr_tgt = ir_ff[11] ? (pc_ff + off11) : regs_ff[fb];

   always_comb begin
      unique case (lc3s_pkg::opcode_type'(ir_ff[15:12]))
         lc3s_pkg::OP_ADD: alu = regs_ff[fb] + src2;
         lc3s_pkg::OP_AND: alu = regs_ff[fb] & src2;
         lc3s_pkg::OP_NOT: alu = ~regs_ff[fb];
         default:          alu = a1;
      endcase
   end

   always_comb begin
      case (cw.asel)
         lc3s_pkg::AS_A1:   addr = a1;
         lc3s_pkg::AS_BOFF: addr = boff;
         lc3s_pkg::AS_MAR:  addr = mar_ff;
         lc3s_pkg::AS_VEC:  addr = {8'd0, ir_ff[7:0]};
         lc3s_pkg::AS_INFO: addr = info_ff;
         lc3s_pkg::AS_LOAD: addr = waddr_ff;
         default:           addr = pc_ff;
      endcase
      case (cw.wsel)
         lc3s_pkg::WS_AT:   wdat = at_ff;
         lc3s_pkg::WS_LOAD: wdat = wdata_ff;
         default:           wdat = regs_ff[fd];
      endcase
      case (status_ff)
         lc3s_pkg::ST_RD_FAULT: fault_en = mask_ff[0];
         lc3s_pkg::ST_WR_FAULT: fault_en = mask_ff[1];
         lc3s_pkg::ST_UNIMPL:   fault_en = mask_ff[2];
         default:               fault_en = 1'b0;
      endcase
   end

   assign is_io = (addr == lc3s_pkg::KBSR_ADDR) || (addr == lc3s_pkg::KBDR_ADDR) ||
                  (addr == lc3s_pkg::DSR_ADDR) || (addr == lc3s_pkg::DDR_ADDR);
   assign in_range = {1'b0, addr} < 17'(lc3s_pkg::MEM_WORDS);
   assign acc_fault = ((cw.mem_op == lc3s_pkg::MO_READ) || (cw.mem_op == lc3s_pkg::MO_WRITE))
                      && !is_io && !in_range;
   assign act = !acc_fault;

   always_comb begin
      if (addr == lc3s_pkg::KBSR_ADDR)      io_val = kready_ff ? lc3s_pkg::READY_WORD : 16'd0;
      else if (addr == lc3s_pkg::KBDR_ADDR) io_val = kready_ff ? {8'd0, kchar_ff} : 16'd0;
      else if (addr == lc3s_pkg::DSR_ADDR)  io_val = lc3s_pkg::READY_WORD;
      else                                  io_val = 16'd0;
   end

   always_comb begin
      case (cw.mem_op)
         lc3s_pkg::MO_WRITE: mem_we = !is_io && in_range;
         lc3s_pkg::MO_SOFT:  mem_we = fault_en && !is_io && in_range;
         lc3s_pkg::MO_RAW:   mem_we = in_range;
         default:            mem_we = 1'b0;
      endcase
      disp_we = ((cw.mem_op == lc3s_pkg::MO_WRITE) ||
                 ((cw.mem_op == lc3s_pkg::MO_SOFT) && fault_en)) &&
                (addr == lc3s_pkg::DDR_ADDR);
   end

   always_comb begin
      rf_we = 1'b0;
      rf_wa = fd;
      rf_wd = alu;
      case (cw.ract)
         lc3s_pkg::RA_ALU:     rf_we = 1'b1;
         lc3s_pkg::RA_LOADREG: begin
            rf_we = 1'b1;
            rf_wd = rd_data;
         end
         lc3s_pkg::RA_JSR: begin
            rf_we = 1'b1;
            rf_wa = 3'd7;
            rf_wd = pc_ff;
         end
         lc3s_pkg::RA_TRAP: begin
            rf_we = 1'b1;
            rf_wa = keyvec ? 3'd0 : 3'd7;
            rf_wd = keyvec ? (kready_ff ? {8'd0, kchar_ff} : 16'd0) : pc_ff;
         end
         default: rf_we = 1'b0;
      endcase
   end

   assign stat.fault    = acc_fault;
   assign stat.keyvec   = keyvec;
   assign stat.opcode   = lc3s_pkg::opcode_type'(rd_data[15:12]);
   assign stat.out_free = out_free;

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr[lc3s_pkg::MEM_AW-1:0]] <= wdat;
      memq_ff   <= mem[addr[lc3s_pkg::MEM_AW-1:0]];
      io_hit_ff <= is_io;
      io_val_ff <= io_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handler_ff   <= 16'd0;
         info_ff      <= 16'd0;
         mask_ff      <= 3'd0;
         pc_ff        <= 16'd0;
         flag_ff      <= 3'd0;
         count_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lc3s_pkg::CSR_HANDLER: handler_ff <= csr_write_data;
               lc3s_pkg::CSR_INFO:    info_ff    <= csr_write_data;
               lc3s_pkg::CSR_MASK:    mask_ff    <= csr_write_data[2:0];
               default: ;
            endcase
         end
         if (rf_we && act) regs_ff[rf_wa] <= rf_wd;
         if (act) begin
            case (cw.ract)
               lc3s_pkg::RA_IR:      pc_ff <= pc_ff + 16'd1;
               lc3s_pkg::RA_BR: begin
                  if ((ir_ff != 16'd0) && ((cc & fd & lc3s_pkg::COND_MASK) != 3'd0))
                     pc_ff <= a1;
               end
               lc3s_pkg::RA_ALU, lc3s_pkg::RA_LOADREG, lc3s_pkg::RA_SETCC: flag_ff <= fd;
               lc3s_pkg::RA_JSR:     pc_ff <= jsr_tgt;
               lc3s_pkg::RA_JMP:     pc_ff <= regs_ff[fb];
               lc3s_pkg::RA_TRAPPC:  pc_ff <= rd_data;
               lc3s_pkg::RA_SETPC:   pc_ff <= waddr_ff;
               lc3s_pkg::RA_FAULT: begin
                  count_ff <= count_ff + 16'd1;
                  if (fault_en) pc_ff <= handler_ff;
               end
               default: ;
            endcase
         end
         if ((cw.ract == lc3s_pkg::RA_EMIT) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         waddr_ff   <= req_word_address;
         wdata_ff   <= req_word_data;
         kready_ff  <= req_key_ready;
         kchar_ff   <= req_key_char;
         status_ff  <= lc3s_pkg::ST_OK;
         faddr_ff   <= 16'd0;
         taken_ff   <= 1'b0;
         dispv_ff   <= 1'b0;
         dispw_ff   <= 16'd0;
         took_ff    <= 1'b0;
         rti_ff     <= 1'b0;
         rfirst_ff  <= 16'd0;
         rsecond_ff <= 16'd0;
         roff_ff    <= 6'd0;
      end else begin
         if (acc_fault) begin
            status_ff <= (cw.mem_op == lc3s_pkg::MO_READ) ? lc3s_pkg::ST_RD_FAULT
                                                          : lc3s_pkg::ST_WR_FAULT;
            faddr_ff  <= addr;
         end
         if ((cw.mem_op == lc3s_pkg::MO_READ) && (addr == lc3s_pkg::KBDR_ADDR) && kready_ff)
            took_ff <= 1'b1;
         if (disp_we) begin
            dispv_ff <= 1'b1;
            dispw_ff <= wdat;
         end
         if (act) begin
            case (cw.ract)
               lc3s_pkg::RA_IR: begin
                  ir_ff <= rd_data;
                  at_ff <= pc_ff;
               end
               lc3s_pkg::RA_BR: begin
                  if (ir_ff == 16'd0) status_ff <= lc3s_pkg::ST_HALT;
               end
               lc3s_pkg::RA_MAR: mar_ff <= rd_data;
               lc3s_pkg::RA_RTI: begin
                  rti_ff     <= 1'b1;
                  rfirst_ff  <= regs_ff[fd];
                  rsecond_ff <= regs_ff[fb];
                  roff_ff    <= ir_ff[5:0];
               end
               lc3s_pkg::RA_RES:   status_ff <= lc3s_pkg::ST_UNIMPL;
               lc3s_pkg::RA_TRAP: begin
                  if (keyvec && kready_ff) took_ff <= 1'b1;
               end
               lc3s_pkg::RA_FAULT: begin
                  if (fault_en) taken_ff <= 1'b1;
               end
               lc3s_pkg::RA_EMIT: begin
                  if (out_free) begin
                     rsp_status        <= status_ff;
                     rsp_fault_address <= faddr_ff;
                     rsp_handler_taken <= taken_ff;
                     rsp_pc_now        <= pc_ff;
                     rsp_display_valid <= dispv_ff;
                     rsp_display_word  <= dispw_ff;
                     rsp_key_taken     <= took_ff;
                     rsp_rti_request   <= rti_ff;
                     rsp_rti_first     <= rfirst_ff;
                     rsp_rti_second    <= rsecond_ff;
                     rsp_rti_offset    <= $signed(roff_ff);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/lc3_instruction_step_unit.sv
`timescale 1ns / 1ps
// LC-3 instruction step unit: a 16-bit LC-3 core stepped one item at a time.
// The top level joins the microcode sequencer lc3s_useq and the datapath lc3s_dpath.
//
// One item is taken at a time; a finished result waits in an output register while
// the next item runs. An execute item runs fetch, decode, execute and result steps:
// BR, ADD/AND/NOT/LEA, ST/STR, JSR, JMP, RTI and the keyboard trap execute in a single
// step, LD/LDR run a read and a write-back, RES the fault step, STI a pointer read, an
// address latch and the store, a vector trap a vector read and a PC load, LDI a pointer
// read, an address latch, the data read and the write-back; a faulting access goes to the
// fault step. Load and set-PC items run their own step and the result step, the unused
// kind only the result step, which holds while the output register is full; the next
// transfer can come as soon as the result appears. Single-port word memory with registered
// read data makes each fetch or data access its own step. Memory needs no clearing pass.
module lc3_instruction_step_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [15:0]        req_word_address,
   input  logic [15:0]        req_word_data,
   input  logic               req_key_ready,
   input  logic [7:0]         req_key_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_fault_address,
   output logic               rsp_handler_taken,
   output logic [15:0]        rsp_pc_now,
   output logic               rsp_display_valid,
   output logic [15:0]        rsp_display_word,
   output logic               rsp_key_taken,
   output logic               rsp_rti_request,
   output logic [15:0]        rsp_rti_first,
   output logic [15:0]        rsp_rti_second,
   output logic signed [5:0]  rsp_rti_offset
);

   lc3s_pkg::ucode_type   cw;
   lc3s_pkg::dp_stat_type stat;
   logic                  start;

   lc3s_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .stat      (stat),
      .cw        (cw),
      .start     (start)
   );

   lc3s_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cw                (cw),
      .start             (start),
      .stat              (stat),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_word_address  (req_word_address),
      .req_word_data     (req_word_data),
      .req_key_ready     (req_key_ready),
      .req_key_char      (req_key_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_fault_address (rsp_fault_address),
      .rsp_handler_taken (rsp_handler_taken),
      .rsp_pc_now        (rsp_pc_now),
      .rsp_display_valid (rsp_display_valid),
      .rsp_display_word  (rsp_display_word),
      .rsp_key_taken     (rsp_key_taken),
      .rsp_rti_request   (rsp_rti_request),
      .rsp_rti_first     (rsp_rti_first),
      .rsp_rti_second    (rsp_rti_second),
      .rsp_rti_offset    (rsp_rti_offset)
   );

endmodule
